@@ hdl/ldm_pkg.sv @@
// ----------------------------------------------------------------------------
// Length-prefixed deframer package
// Shared types and constants for the deframer front end, queue and back end.
// ----------------------------------------------------------------------------
package ldm_pkg;

    // Header layout: two command bytes, then a four-byte big-endian length.
    localparam int HDR_LEN = 6;
    localparam int MIN_LEN = 4;
    localparam int CFG_MAX_W = 13;
    localparam int CFG_MAX_LIMIT = (1 << CFG_MAX_W) - 1;

    // Frame positions that feed the response match and the acknowledge check.
    localparam logic [3:0] POS_FIRST_PAYLOAD = 4'd6;
    localparam logic [3:0] POS_RESP_FLAG = 4'd6;
    localparam logic [3:0] POS_SEQUENCE = 4'd9;
    localparam logic [3:0] POS_ACK_FIRST = 4'd10;
    localparam logic [3:0] POS_ACK_SECOND = 4'd11;
    localparam logic [3:0] POS_SATURATE = 4'd15;

    localparam logic [7:0] ACK_FIRST_BYTE = 8'h22;
    localparam logic [7:0] ACK_SECOND_BYTE = 8'h00;
    localparam logic [7:0] RESP_OK_BYTE = 8'h00;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_MATCH_COMMAND = 16'd10078;
    localparam logic [7:0] RST_MATCH_SEQUENCE = 8'd1;
    localparam logic [12:0] RST_MAX_PAYLOAD = 13'd4096;

    // Queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_MATCH_COMMAND = 2'd0,
        REG_MATCH_SEQUENCE = 2'd1,
        REG_MAX_PAYLOAD = 2'd2
    } ldm_reg_idx_t;

    typedef struct packed {
        logic [15:0] match_command;
        logic [7:0] match_sequence;
        logic [12:0] max_payload;
    } ldm_cfg_t;

    // One queued piece of work: a whole accepted header or one payload byte.
    typedef struct packed {
        logic is_header;
        logic [8*HDR_LEN-1:0] bytes;    // byte 0 in the lowest bits
        logic last;
        logic match_ok;
        logic ack;
    } ldm_entry_t;

endpackage

@@ hdl/ldm_front.sv @@
// ----------------------------------------------------------------------------
// Deframer front end
// Hunts for a header with a plausible length, then classifies payload bytes
// and works out the match and acknowledge flags for the frame's last byte.
// ----------------------------------------------------------------------------
module ldm_front #(
    parameter int MAX_FRAME_PAYLOAD = 4096
) (
    input  logic clk,
    input  logic rst_n,
    input  ldm_pkg::ldm_cfg_t cfg,
    input  logic in_valid,
    input  logic [7:0] in_data,
    output logic in_ready,
    input  logic queue_full,
    output logic push,
    output ldm_pkg::ldm_entry_t entry
);
    import ldm_pkg::*;

    // Largest length that can ever pass, and the counter width it needs.
    localparam int CAP = (MAX_FRAME_PAYLOAD < CFG_MAX_LIMIT) ? MAX_FRAME_PAYLOAD
                                                             : CFG_MAX_LIMIT;
    localparam int LEN_W = $clog2(CAP + 1);

    logic [7:0] win_reg [0:HDR_LEN-2];
    logic [2:0] fill_reg;
    logic in_payload_reg;
    logic [LEN_W-1:0] bytes_left_reg;
    logic [3:0] pos_reg;
    logic [15:0] seen_command_reg;
    logic resp_ok_reg;
    logic [7:0] seen_seq_reg;
    logic ack_first_reg;
    logic ack_second_reg;

    logic accept;
    logic [31:0] len;
    logic [LEN_W-1:0] limit;
    logic len_good;
    logic hdr_done;
    logic resp_eff;
    logic [7:0] seq_eff;
    logic ack_first_eff;
    logic ack_second_eff;
    logic last;

    assign in_ready = !queue_full;
    assign accept = in_valid && in_ready;

    // Length check on the completed window; the newest byte is the length LSB.
    assign len = {win_reg[2], win_reg[3], win_reg[4], in_data};
    assign limit = (cfg.max_payload > 13'(CAP)) ? LEN_W'(CAP)
                                                : LEN_W'(cfg.max_payload);
    assign len_good = (len >= 32'(MIN_LEN)) && (len[31:LEN_W] == '0)
                      && (len[LEN_W-1:0] <= limit);
    assign hdr_done = !in_payload_reg && (fill_reg == 3'(HDR_LEN - 1));

    // Field values as they stand after this byte is taken into account.
    assign resp_eff = (pos_reg == POS_RESP_FLAG) ? (in_data == RESP_OK_BYTE) : resp_ok_reg;
    assign seq_eff = (pos_reg == POS_SEQUENCE) ? in_data : seen_seq_reg;
    assign ack_first_eff = (pos_reg == POS_ACK_FIRST) ? (in_data == ACK_FIRST_BYTE)
                                                      : ack_first_reg;
    assign ack_second_eff = (pos_reg == POS_ACK_SECOND) ? (in_data == ACK_SECOND_BYTE)
                                                        : ack_second_reg;
    assign last = (bytes_left_reg == LEN_W'(1));

    // Queue entry for a payload byte or an accepted header.
    always_comb
    begin
        entry.is_header = !in_payload_reg;
        entry.bytes = {in_data, win_reg[4], win_reg[3], win_reg[2], win_reg[1], win_reg[0]};
        entry.last = in_payload_reg && last;
        entry.match_ok = in_payload_reg && last && (seen_command_reg == cfg.match_command)
                         && resp_eff && (seq_eff == cfg.match_sequence);
        entry.ack = in_payload_reg && last && ack_first_eff && ack_second_eff;
        if (!in_payload_reg)
        begin
            entry.bytes[7:0] = win_reg[0];
        end
        else
        begin
            entry.bytes[7:0] = in_data;
        end
    end

    assign push = accept && (in_payload_reg || (hdr_done && len_good));

    // Frame tracking state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            in_payload_reg <= 1'b0;
            bytes_left_reg <= '0;
            pos_reg <= '0;
            seen_command_reg <= '0;
            resp_ok_reg <= 1'b0;
            seen_seq_reg <= '0;
            ack_first_reg <= 1'b0;
            ack_second_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (in_payload_reg)
            begin
                resp_ok_reg <= resp_eff;
                seen_seq_reg <= seq_eff;
                ack_first_reg <= ack_first_eff;
                ack_second_reg <= ack_second_eff;
                bytes_left_reg <= bytes_left_reg - LEN_W'(1);
                if (pos_reg != POS_SATURATE)
                begin
                    pos_reg <= pos_reg + 4'd1;
                end
                if (last)
                begin
                    in_payload_reg <= 1'b0;
                    fill_reg <= '0;
                end
            end
            else if (!hdr_done)
            begin
                fill_reg <= fill_reg + 3'd1;
            end
            else if (len_good)
            begin
                seen_command_reg <= {win_reg[0], win_reg[1]};
                resp_ok_reg <= 1'b0;
                seen_seq_reg <= '0;
                ack_first_reg <= 1'b0;
                ack_second_reg <= 1'b0;
                in_payload_reg <= 1'b1;
                bytes_left_reg <= len[LEN_W-1:0];
                pos_reg <= POS_FIRST_PAYLOAD;
                fill_reg <= '0;
            end
        end
    end

    // Header window: fill in order, slide by one byte on a bad length.
    always_ff @(posedge clk)
    begin
        if (accept && !in_payload_reg)
        begin
            if (!hdr_done)
            begin
                win_reg[fill_reg] <= in_data;
            end
            else if (!len_good)
            begin
                for (int i = 0; i < HDR_LEN - 2; i++)
                begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[HDR_LEN-2] <= in_data;
            end
        end
    end

endmodule

@@ hdl/ldm_queue.sv @@
// ----------------------------------------------------------------------------
// Deframer work queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ldm_queue (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  ldm_pkg::ldm_entry_t push_entry,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output ldm_pkg::ldm_entry_t head
);
    import ldm_pkg::*;

    ldm_entry_t slot_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0] count_reg;
    logic do_push;
    logic do_pop;

    assign full = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && head_valid;

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (QPTR_W + 1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (QPTR_W + 1)'(1);
            end
        end
    end

    // The occupancy never exceeds the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W + 1)'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    // An empty or full queue has its pointers together.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with occupancy");

    // A push into a queue with room raises the occupancy unless a pop goes with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + (QPTR_W + 1)'(1)))
        else $error("queue push lost");

endmodule

@@ hdl/ldm_back.sv @@
// ----------------------------------------------------------------------------
// Deframer back end
// Expands queued headers into six frame bytes and drives the output register.
// ----------------------------------------------------------------------------
module ldm_back (
    input  logic clk,
    input  logic rst_n,
    input  logic head_valid,
    input  ldm_pkg::ldm_entry_t head,
    output logic pop,
    output logic m_tvalid,
    input  logic m_tready,
    output logic [7:0] m_tdata,
    output logic m_tlast,
    output logic [3:0] m_tuser
);
    import ldm_pkg::*;

    logic [2:0] sub_reg;
    logic m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic m_tlast_reg;
    logic [3:0] m_tuser_reg;

    logic load;
    logic hdr_end;
    logic [7:0] res_byte;
    logic [3:0] res_user;
    logic res_last;

    assign load = head_valid && (!m_tvalid_reg || m_tready);
    assign hdr_end = (sub_reg == 3'(HDR_LEN - 1));
    assign pop = load && (!head.is_header || hdr_end);

    // Result picked from the head entry.
    always_comb
    begin
        if (head.is_header)
        begin
            res_byte = head.bytes[8*sub_reg +: 8];
            res_last = 1'b0;
            res_user = {hdr_end, 1'b0, 1'b0, (sub_reg == 3'd0)};
        end
        else
        begin
            res_byte = head.bytes[7:0];
            res_last = head.last;
            res_user = {1'b1, head.ack, head.match_ok, 1'b0};
        end
    end

    // Header byte index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg <= '0;
        end
        else if (load && head.is_header)
        begin
            sub_reg <= hdr_end ? 3'd0 : sub_reg + 3'd1;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_tdata_reg <= res_byte;
            m_tlast_reg <= res_last;
            m_tuser_reg <= res_user;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tlast = m_tlast_reg;
    assign m_tuser = m_tuser_reg;

    // The header index stays inside the header.
    assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg <= 3'(HDR_LEN - 1))
        else $error("header index out of range");

    // A partly sent header stays at the head of the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sub_reg != 3'd0) |-> (head_valid && head.is_header))
        else $error("header left the queue before all bytes were sent");

    // The last byte of a frame always closes its input's burst.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tlast_reg) |-> m_tuser_reg[3])
        else $error("frame end without burst end");

endmodule

@@ hdl/length_prefixed_deframer_matcher_core.sv @@
// ----------------------------------------------------------------------------
// Length-prefixed deframer and response matcher
// Finds frames in a byte stream by their length field and flags awaited
// responses and success acknowledges on each frame's last byte.
// ----------------------------------------------------------------------------
// Path: each result is registered in a queue slot, then in the output
//   register; a good header yields six results. Throughput: one input
//   byte per cycle unless the queue is full; the eight-entry queue absorbs
//   the five extra results of each header while the next header is hunted.
// Reset: hunting for a header, queue and output empty, configuration at its
//   reset values; header window contents are undefined until refilled.
module length_prefixed_deframer_matcher_core #(
    parameter int MAX_FRAME_PAYLOAD = 4096
) (
    input  logic clk,
    input  logic rst_n,
    // Configuration write channel.
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data,
    // Input stream.
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [7:0] s_tdata,     // [7:0] rx_byte
    // Output stream.
    output logic m_tvalid,
    input  logic m_tready,
    output logic [7:0] m_tdata,     // [7:0] frame_byte
    output logic m_tlast,           // last_of_frame
    output logic [3:0] m_tuser      // [0] first_of_frame, [1] frame_matches,
                                    // [2] success_ack, [3] last_in_burst
);
    import ldm_pkg::*;

    ldm_cfg_t cfg_reg;
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    ldm_entry_t q_in;
    ldm_entry_t q_head;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_command <= RST_MATCH_COMMAND;
            cfg_reg.match_sequence <= RST_MATCH_SEQUENCE;
            cfg_reg.max_payload <= RST_MAX_PAYLOAD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MATCH_COMMAND:  cfg_reg.match_command <= cfg_data;
                REG_MATCH_SEQUENCE: cfg_reg.match_sequence <= cfg_data[7:0];
                REG_MAX_PAYLOAD:    cfg_reg.max_payload <= cfg_data[12:0];
                default:            ;
            endcase
        end
    end

    ldm_front #(
        .MAX_FRAME_PAYLOAD(MAX_FRAME_PAYLOAD)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .in_valid(s_tvalid),
        .in_data(s_tdata),
        .in_ready(s_tready),
        .queue_full(q_full),
        .push(q_push),
        .entry(q_in)
    );

    ldm_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(q_push),
        .push_entry(q_in),
        .pop(q_pop),
        .full(q_full),
        .head_valid(q_valid),
        .head(q_head)
    );

    ldm_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .head_valid(q_valid),
        .head(q_head),
        .pop(q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

endmodule

@@ test/length_prefixed_deframer_matcher_core_tb.sv @@
// ----------------------------------------------------------------------------
// Length-prefixed deframer and matcher testbench
// Drives byte streams with well-formed, broken and noisy frames through the
// core under several register settings. It predicts every output transaction
// in a scoreboard and checks each one field by field. Both stream sides idle
// at random, and one phase holds the output back long enough to stall input.
// ----------------------------------------------------------------------------
module length_prefixed_deframer_matcher_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ldm_pkg::*;

    localparam int unsigned FRAME_PAYLOAD_CAP = 4096;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    // One output transaction as the scoreboard sees it.
    typedef struct packed {
        logic [7:0] data;
        logic first;
        logic last;
        logic match_ok;
        logic ack;
        logic burst_end;
    } frame_out_t;

    // Scoreboard: tracks the deframer state and holds the frame bytes still due.
    class deframer_scoreboard;
        int unsigned payload_cap;
        logic [15:0] want_cmd;
        logic [7:0] want_seq;
        logic [CFG_MAX_W-1:0] max_len;

        logic [7:0] hdr[HDR_LEN];
        int unsigned hdr_fill;
        bit in_frame;
        int unsigned bytes_left;
        int unsigned frame_pos;
        logic [15:0] seen_cmd;
        bit resp_ok;
        logic [7:0] seen_seq;
        bit ack_hi_ok;
        bit ack_lo_ok;

        frame_out_t frames_due[$];
        int unsigned n_errors;

        function new(int unsigned cap);
            payload_cap = cap;
            want_cmd = RST_MATCH_COMMAND;
            want_seq = RST_MATCH_SEQUENCE;
            max_len = RST_MAX_PAYLOAD;
            foreach (hdr[i]) hdr[i] = 8'h00;
            hdr_fill = 0;
            in_frame = 1'b0;
            bytes_left = 0;
            frame_pos = 0;
            seen_cmd = '0;
            resp_ok = 1'b0;
            seen_seq = '0;
            ack_hi_ok = 1'b0;
            ack_lo_ok = 1'b0;
            n_errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_MATCH_COMMAND:  want_cmd = val;
                REG_MATCH_SEQUENCE: want_seq = val[7:0];
                REG_MAX_PAYLOAD:    max_len = val[CFG_MAX_W-1:0];
                default: ;
            endcase
        endfunction

        // Largest length field the block accepts right now.
        function int unsigned payload_limit();
            return (max_len > payload_cap) ? payload_cap : max_len;
        endfunction

        function void queue_result(logic [7:0] b, bit first, bit last, bit match_ok,
                                   bit ack, bit burst_end);
            frame_out_t r;
            r.data = b;
            r.first = first;
            r.last = last;
            r.match_ok = match_ok;
            r.ack = ack;
            r.burst_end = burst_end;
            frames_due = {frames_due, r};
        endfunction

        function void note_rx_byte(logic [7:0] b);
            logic [31:0] len;
            bit last;
            if (in_frame) begin
                // Payload byte: capture the fields that the match and ack depend on.
                if (frame_pos == POS_RESP_FLAG) resp_ok = (b == RESP_OK_BYTE);
                if (frame_pos == POS_SEQUENCE) seen_seq = b;
                if (frame_pos == POS_ACK_FIRST) ack_hi_ok = (b == ACK_FIRST_BYTE);
                if (frame_pos == POS_ACK_SECOND) ack_lo_ok = (b == ACK_SECOND_BYTE);
                if (bytes_left > 0) bytes_left--;
                frame_pos++;
                last = (bytes_left == 0);
                queue_result(b, 1'b0, last,
                             last && seen_cmd == want_cmd && resp_ok && seen_seq == want_seq,
                             last && ack_hi_ok && ack_lo_ok, 1'b1);
                if (last) begin
                    in_frame = 1'b0;
                    hdr_fill = 0;
                end
                return;
            end

            // Hunting: fill the header window, then judge its length field.
            if (hdr_fill >= HDR_LEN) hdr_fill = 0;
            hdr[hdr_fill] = b;
            hdr_fill++;
            if (hdr_fill < HDR_LEN) return;

            len = {hdr[2], hdr[3], hdr[4], hdr[5]};
            if (len < MIN_LEN || len > payload_limit()) begin
                // Bad length: drop the oldest byte and keep hunting.
                for (int i = 0; i < HDR_LEN - 1; i++) hdr[i] = hdr[i + 1];
                hdr_fill = HDR_LEN - 1;
                return;
            end

            for (int i = 0; i < HDR_LEN; i++)
                queue_result(hdr[i], i == 0, 1'b0, 1'b0, 1'b0, i == HDR_LEN - 1);
            seen_cmd = {hdr[0], hdr[1]};
            resp_ok = 1'b0;
            seen_seq = '0;
            ack_hi_ok = 1'b0;
            ack_lo_ok = 1'b0;
            in_frame = 1'b1;
            bytes_left = len;
            frame_pos = HDR_LEN;
            hdr_fill = 0;
        endfunction

        function string show(frame_out_t r);
            return $sformatf("byte %02h first %0d last %0d match %0d ack %0d burst_end %0d",
                             r.data, r.first, r.last, r.match_ok, r.ack, r.burst_end);
        endfunction

        function void flag(string msg);
            n_errors++;
            if (n_errors <= 10) $display("ERROR: %s", msg);
        endfunction

        function void check_frame_byte(frame_out_t got);
            frame_out_t want;
            if (frames_due.size() == 0) begin
                flag($sformatf("output with nothing pending: %s", show(got)));
                return;
            end
            want = frames_due.pop_front();
            if (got.data !== want.data || got.first !== want.first ||
                got.last !== want.last || got.match_ok !== want.match_ok ||
                got.ack !== want.ack || got.burst_end !== want.burst_end)
                flag($sformatf("mismatch: got %s, want %s", show(got), show(want)));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;       // [7:0] rx_byte
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] frame_byte
    logic m_tlast;                  // last_of_frame
    logic [3:0] m_tuser;            // [0] first_of_frame, [1] frame_matches,
                                    // [2] success_ack, [3] last_in_burst

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    bit hold_req = 1'b0;
    int unsigned cycle_count = 0;
    deframer_scoreboard sb;

    length_prefixed_deframer_matcher_core #(
        .MAX_FRAME_PAYLOAD(FRAME_PAYLOAD_CAP)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    always #1 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Check every output transaction against the oldest pending frame byte.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_frame_byte('{m_tdata, m_tuser[0], m_tlast, m_tuser[1], m_tuser[2],
                                  m_tuser[3]});
    end

    // Output side: random stalls per transaction, and a long hold-off on request.
    initial
    begin : sink
        int unsigned stall;
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (rx_idle)
            begin
                stall = $urandom_range(0, 5);
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_rx_byte(b);
    endtask

    task automatic send_bytes(input logic [7:0] q[$]);
        foreach (q[i]) send_byte(q[i]);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic cfg_idle();
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] cmd, input logic [15:0] seq,
                              input logic [15:0] max_val);
        cfg_write(REG_MATCH_COMMAND, cmd);
        cfg_write(REG_MATCH_SEQUENCE, seq);
        cfg_write(REG_MAX_PAYLOAD, max_val);
        cfg_idle();
    endtask

    // Stop sending, wait for every pending frame byte, then let the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.frames_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Finish any open frame, then push bytes that no length check can accept,
    // so that the next header with two nonzero command bytes is found in place.
    task automatic resync();
        while (sb.in_frame) send_byte(8'($urandom));
        repeat (3) send_byte(8'hFF);
    endtask

    function automatic void build_frame(ref logic [7:0] q[$], input logic [15:0] cmd,
                                        input logic [31:0] len_field,
                                        input int unsigned n_payload,
                                        input bit resp_good, input bit seq_good,
                                        input bit ack_good);
        logic [7:0] b;
        q = {q, cmd[15:8]};
        q = {q, cmd[7:0]};
        q = {q, len_field[31:24]};
        q = {q, len_field[23:16]};
        q = {q, len_field[15:8]};
        q = {q, len_field[7:0]};
        for (int unsigned pos = HDR_LEN; pos < HDR_LEN + n_payload; pos++)
        begin
            b = 8'($urandom);
            if (pos == POS_RESP_FLAG && resp_good) b = RESP_OK_BYTE;
            if (pos == POS_SEQUENCE && seq_good) b = sb.want_seq;
            if (pos == POS_ACK_FIRST && ack_good) b = ACK_FIRST_BYTE;
            if (pos == POS_ACK_SECOND && ack_good) b = ACK_SECOND_BYTE;
            q = {q, b};
        end
    endfunction

    // Mostly well-formed frames with random content, some bad lengths and noise.
    function automatic void make_sequence(ref logic [7:0] q[$]);
        int unsigned lim;
        int unsigned top;
        int unsigned kind;
        logic [31:0] len;
        logic [15:0] cmd;
        lim = sb.payload_limit();
        kind = $urandom_range(0, 9);
        cmd = $urandom_range(0, 1) ? sb.want_cmd : 16'($urandom);
        q.delete();
        if (kind <= 7)
        begin
            top = (lim < MIN_LEN) ? 8 : lim;
            if (top > 40) top = 40;
            if (top > 16 && $urandom_range(0, 7) != 0) top = 16;
            len = $urandom_range(MIN_LEN, top);
            build_frame(q, cmd, len, len, $urandom_range(0, 1), $urandom_range(0, 1),
                        $urandom_range(0, 1));
        end
        else if (kind == 8)
        begin
            case ($urandom_range(0, 2))
                0:       len = $urandom_range(0, MIN_LEN - 1);
                1:       len = lim + $urandom_range(1, 3);
                default: len = $urandom;
            endcase
            build_frame(q, cmd, len, 0, 1'b0, 1'b0, 1'b0);
        end
        else
        begin
            repeat ($urandom_range(1, 4)) q = {q, 8'($urandom)};
        end
    endfunction

    task automatic send_random(input int unsigned budget);
        logic [7:0] q[$];
        int unsigned sent;
        sent = 0;
        while (sent < budget)
        begin
            make_sequence(q);
            sent += q.size();
            send_bytes(q);
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] q[$];
        sb = new(FRAME_PAYLOAD_CAP);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: a twelve-byte awaited response that is also a success ack.
        q = '{8'h27, 8'h5E, 8'h00, 8'h00, 8'h00, 8'h06,
              8'h00, 8'hFF, 8'hFF, 8'h01, 8'h22, 8'h00};
        send_bytes(q);
        drain();

        // All-ones match values, masked register data, small maximum. A length
        // just above the maximum is skipped, then a short frame matches but
        // cannot be an ack.
        set_config(16'hFFFF, 16'hA5FF, 16'hE008);
        q = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h09,
              8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h04,
              8'h00, 8'h12, 8'h34, 8'hFF};
        send_bytes(q);
        drain();

        // Random match values with a moderate maximum.
        set_config(16'($urandom), 16'($urandom), 16'($urandom_range(12, 24)));
        send_random(40);
        drain();

        // Maxima below four: every length is rejected and the block only hunts.
        set_config(16'($urandom), 16'($urandom), 16'h0000);
        send_random(8);
        drain();
        set_config(16'h0000, 16'h0000, 16'h0003);
        send_random(8);
        drain();

        // Smallest usable maximum, no idling on either side; a write to an
        // unmapped index must change nothing.
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        set_config(16'($urandom), 16'($urandom), 16'h0004);
        cfg_write(REG_UNMAPPED, 16'hBEEF);
        cfg_idle();
        send_random(24);
        drain();

        // Register maximum above the payload cap: one byte past the cap is
        // rejected, while short frames still pass.
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        set_config(16'h5A5A, 16'($urandom), 16'h1FFF);
        resync();
        q = '{8'hA5, 8'hA5, 8'h00, 8'h00, 8'h10, 8'h01};
        send_bytes(q);
        send_random(16);
        drain();

        // Back-pressure: the output holds off while input keeps coming.
        tx_idle = 1'b0;
        set_config(16'($urandom), 16'($urandom), 16'd40);
        hold_req = 1'b1;
        send_random(32);
        drain();

        // Command register changed in the middle of a frame; the match uses the
        // value present at the last byte.
        tx_idle = 1'b1;
        resync();
        q.delete();
        build_frame(q, 16'h1234, 8, 8, 1'b1, 1'b1, 1'b1);
        for (int i = 0; i < 8; i++) send_byte(q[i]);
        drain();
        cfg_write(REG_MATCH_COMMAND, 16'h1234);
        cfg_idle();
        for (int i = 8; i < q.size(); i++) send_byte(q[i]);
        drain();

        // Back to the reset values.
        set_config(RST_MATCH_COMMAND, {8'h00, RST_MATCH_SEQUENCE}, {3'b000, RST_MAX_PAYLOAD});
        send_random(32);
        drain();

        if (sb.n_errors == 0 && sb.frames_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/ldm_pkg.sv
hdl/ldm_front.sv
hdl/ldm_queue.sv
hdl/ldm_back.sv
hdl/length_prefixed_deframer_matcher_core.sv
test/length_prefixed_deframer_matcher_core_tb.sv
